### src/skap_pkg.sv
// Shared types and codes for the sorted key array.
package skap_pkg;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned POS_W = 4;
    localparam int unsigned MAX_POS = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic                    ins_en;
        logic                    rem_en;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
    } t_skap_cmd;

endpackage

### src/skap_cell.sv
// One slot of the sorted key row: compare against the new key and shift.
module skap_cell import skap_pkg::*; #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 5
) (
    input  logic                    i_clk,
    input  t_skap_cmd               i_cmd,
    input  logic [CNT_W-1:0]        i_count,
    input  logic                    i_left_ins,
    input  logic signed [KEY_W-1:0] i_left_key,
    input  logic signed [KEY_W-1:0] i_right_key,
    output logic                    o_ins,
    output logic signed [KEY_W-1:0] o_key
);

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    occupied;
    logic                    at_or_after_pos;

    assign occupied        = 32'(IDX) < 32'(i_count);
    assign at_or_after_pos = 32'(IDX) >= 32'(i_cmd.pos);
    // slot takes part in the insert shift: empty or holds a greater key
    assign o_ins = !occupied || (r_key > i_cmd.key);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_cmd.ins_en && o_ins) begin
            n_key = i_left_ins ? i_left_key : i_cmd.key;
        end else if (i_cmd.rem_en && at_or_after_pos) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

### src/sorted_key_array_insert_remove.sv
// Sorted key array top level: a row of compare and shift cells with a result register.
// Keeps up to CAPACITY signed 32-bit keys in ascending order. An insert puts its key after
// every stored key less than or equal to it; a remove takes out the key at a position and
// returns it. Each word yields one result word with the new count, a full flag and a
// status (insert refused when full, remove position not below count). Every slot is a cell
// that compares and shifts in parallel with its neighbors, so the block takes one word per
// cycle; a result appears in the cycle after its word is taken and the input is held off
// only while an unread result is stalled. The key storage holds no reset state; only the
// count and the result valid flag are cleared.
module sorted_key_array_insert_remove import skap_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic signed [KEY_W-1:0]             i_key,
    input  logic [POS_W-1:0]                    i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [KEY_W-1:0]             o_removed_key,
    output logic [$clog2(CAPACITY+1)-1:0]       o_count,
    output logic                                o_full_res,
    output logic [1:0]                          o_status
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned NPOS  = (CAPACITY < MAX_POS) ? CAPACITY : MAX_POS;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_removed_key;
    logic [CNT_W-1:0]        r_out_count;
    logic                    r_full_res;
    t_status                 r_status;
    t_status                 n_status;
    logic signed [KEY_W-1:0] n_removed_key;

    logic                    accept;
    logic                    is_full;
    logic                    pos_ok;
    t_skap_cmd               cmd;
    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic                    cell_ins [CAPACITY];
    logic signed [KEY_W-1:0] sel_key;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_full    = r_count == CNT_W'(CAPACITY);
    assign pos_ok     = 32'(i_position) < 32'(r_count);

    always_comb begin
        cmd.key    = i_key;
        cmd.pos    = i_position;
        cmd.ins_en = accept && (i_op == OP_INSERT) && !is_full;
        cmd.rem_en = accept && (i_op == OP_REMOVE) && pos_ok;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    left_ins;
        logic signed [KEY_W-1:0] left_key;
        logic signed [KEY_W-1:0] right_key;
        if (g == 0) begin : g_first
            assign left_ins = 1'b0;
            assign left_key = cell_key[g];
        end else begin : g_mid
            assign left_ins = cell_ins[g-1];
            assign left_key = cell_key[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_key = cell_key[g];
        end else begin : g_inner
            assign right_key = cell_key[g+1];
        end
        skap_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_count     (r_count),
            .i_left_ins  (left_ins),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .o_ins       (cell_ins[g]),
            .o_key       (cell_key[g])
        );
    end

    always_comb begin
        sel_key = '0;
        for (int j = 0; j < NPOS; j++) begin
            if (i_position == POS_W'(j)) begin
                sel_key = cell_key[j];
            end
        end
    end

    always_comb begin
        n_count       = r_count;
        n_status      = ST_OK;
        n_removed_key = '0;
        unique case (i_op)
            OP_INSERT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (!pos_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    n_count       = r_count - CNT_W'(1);
                    n_removed_key = sel_key;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed_key <= n_removed_key;
            r_out_count   <= n_count;
            r_full_res    <= n_count == CNT_W'(CAPACITY);
            r_status      <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_removed_key = r_removed_key;
    assign o_count       = r_out_count;
    assign o_full_res    = r_full_res;
    assign o_status      = r_status;

endmodule

### src/skap_checker.sv
// Port-level checks for the sorted key array, bound to the top level.
module skap_checker import skap_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [KEY_W-1:0]       o_removed_key,
    input logic [$clog2(CAPACITY+1)-1:0] o_count,
    input logic                          o_full_res,
    input logic [1:0]                    o_status
);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_count) <= 32'(CAPACITY))
        else $error("count above capacity");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_full_res == (32'(o_count) == 32'(CAPACITY)))
        else $error("full flag disagrees with count");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_removed_key == '0)
        else $error("refused word carries a key");

    a_refused_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> 32'(o_count) == 32'(CAPACITY))
        else $error("full refusal with room left");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_removed_key)
            && $stable(o_count) && $stable(o_status))
        else $error("stalled result word changed");

endmodule

bind sorted_key_array_insert_remove skap_checker #(
    .CAPACITY (CAPACITY)
) u_skap_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_removed_key (o_removed_key),
    .o_count       (o_count),
    .o_full_res    (o_full_res),
    .o_status      (o_status)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for the sorted key array: random insert and remove words against a shadow copy.
import skap_pkg::*;

localparam int unsigned CAPACITY = MAX_POS;
localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);

typedef struct {
    logic signed [KEY_W-1:0] removed_key;
    logic [COUNT_W-1:0]      count;
    logic                    full_res;
    t_status                 status;
} t_key_result;

class sorted_keys_sb;
    logic signed [KEY_W-1:0] keys[CAPACITY];
    int                      n_keys;
    t_key_result             pending[$];
    int                      errors;
    int                      n_words;
    int                      n_checked;
    int                      n_inserts;
    int                      n_removes;
    int                      n_refused;

    function void note_word(logic op, logic signed [KEY_W-1:0] key, logic [POS_W-1:0] pos);
        t_key_result r;
        int          at;
        r.removed_key = '0;
        r.status      = ST_OK;
        n_words++;
        if (op == OP_INSERT) begin
            if (n_keys >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // first stored key strictly greater; equal keys stay ahead
                at = n_keys;
                for (int i = n_keys; i > 0; i--)
                    if (keys[i-1] > key) at = i - 1;
                for (int i = n_keys; i > at; i--)
                    keys[i] = keys[i-1];
                keys[at] = key;
                n_keys++;
                n_inserts++;
            end
        end else begin
            if (int'(pos) >= n_keys) begin
                r.status = ST_RANGE;
            end else begin
                r.removed_key = keys[pos];
                for (int i = int'(pos); i + 1 < n_keys; i++)
                    keys[i] = keys[i+1];
                n_keys--;
                n_removes++;
            end
        end
        if (r.status != ST_OK) n_refused++;
        r.count    = COUNT_W'(n_keys);
        r.full_res = (n_keys == CAPACITY);
        pending.push_back(r);
    endfunction

    function void check_word(logic signed [KEY_W-1:0] removed_key, logic [COUNT_W-1:0] count,
                             logic full_res, logic [1:0] status);
        t_key_result e;
        if (pending.size() == 0) begin
            $error("unexpected result word: removed_key %0d count %0d", removed_key, count);
            errors++;
        end else begin
            e = pending.pop_front();
            n_checked++;
            if (removed_key !== e.removed_key) begin
                $error("removed_key: expected %0d, got %0d", e.removed_key, removed_key);
                errors++;
            end
            if (count !== e.count) begin
                $error("count: expected %0d, got %0d", e.count, count);
                errors++;
            end
            if (full_res !== e.full_res) begin
                $error("full_res: expected %0d, got %0d", e.full_res, full_res);
                errors++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
        end
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 640;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_op = OP_INSERT;
    logic signed [KEY_W-1:0] i_key = '0;
    logic [POS_W-1:0]        i_position = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [KEY_W-1:0] o_removed_key;
    logic [COUNT_W-1:0]      o_count;
    logic                    o_full_res;
    logic [1:0]              o_status;

    sorted_keys_sb sb = new;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            fill_level;
    int            quiet_cycles;

    sorted_key_array_insert_remove #(.CAPACITY(CAPACITY)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_removed_key (o_removed_key),
        .o_count       (o_count),
        .o_full_res    (o_full_res),
        .o_status      (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_word(o_removed_key, o_count, o_full_res, o_status);
            if (i_in_valid && !o_in_stall)
                sb.note_word(i_op, i_key, i_position);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0: return $signed(KEY_W'($urandom_range(8))) - 4;
            1: begin
                case ($urandom_range(3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(logic op, logic signed [KEY_W-1:0] key, logic [POS_W-1:0] pos);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_key      <= key;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        if (op == OP_INSERT && fill_level < CAPACITY) fill_level++;
        if (op == OP_REMOVE && int'(pos) < fill_level) fill_level--;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    task automatic run_phase(int n_words);
        int  mode;
        int  burst;
        int  ins_pct;
        int  sent;
        logic op;
        logic [POS_W-1:0] pos;
        sent = 0;
        while (sent < n_words) begin
            mode  = $urandom_range(3);
            burst = $urandom_range(4, 24);
            case (mode)
                0: ins_pct = 85;
                1: ins_pct = 15;
                default: ins_pct = 50;
            endcase
            repeat (burst) begin
                op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
                // noise bursts pick any position; otherwise mostly a live one
                if (mode == 3 || fill_level == 0 || $urandom_range(9) == 0)
                    pos = POS_W'($urandom_range(CAPACITY - 1));
                else
                    pos = POS_W'($urandom_range(fill_level - 1));
                send_word(op, pick_key(), pos);
                sent++;
            end
        end
    endtask

    initial begin
        tx_idle_pct = 19;
        rx_idle_pct = 58;
        fill_level  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, extremes, equal keys, ignored fields
        send_word(OP_REMOVE, 32'sh1234_5678, '0);
        send_word(OP_INSERT, 32'sh7fff_ffff, '1);
        send_word(OP_INSERT, 32'sh8000_0000, '0);
        send_word(OP_INSERT, '0, 4'h5);
        send_word(OP_INSERT, '0, 4'ha);
        send_word(OP_INSERT, -1, '1);
        send_word(OP_INSERT, 1, '0);
        send_word(OP_REMOVE, -1, '1);
        send_word(OP_REMOVE, 32'sh7fff_ffff, 4'd5);
        send_word(OP_REMOVE, '0, 4'd0);
        // fill up, refuse one, then remove the top slot
        repeat (12) send_word(OP_INSERT, pick_key(), POS_W'($urandom_range(CAPACITY - 1)));
        send_word(OP_INSERT, 32'sh8000_0000, '0);
        send_word(OP_REMOVE, '0, '1);
        drain();

        run_phase(PHASE_WORDS);
        drain();
        tx_idle_pct = 58;
        rx_idle_pct = 19;
        run_phase(PHASE_WORDS);
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(PHASE_WORDS);
        drain();
        repeat (4) @(posedge i_clk);

        $display("tb: %0d words sent, %0d results checked, %0d mismatches", sb.n_words,
                 sb.n_checked, sb.errors);
        $display("tb: %0d inserts, %0d removes, %0d refused (full or out of range)",
                 sb.n_inserts, sb.n_removes, sb.n_refused);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
